// ===== rtl/assert_macros.svh =====
// Assertion helpers for the console line editor checkers.
// Both sample on the rising edge of clk; the first ignores cycles in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define CLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("console line editor check failed");

// Check a property at every edge, reset included.
`define CLE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("console line editor reset check failed");

`endif

// ===== rtl/cle_pkg.sv =====
`timescale 1ns / 1ps
package cle_pkg;

  localparam int DEFAULT_BUF_DEPTH = 128;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DUMP = 8'h10;
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_DEL  = 8'h7F;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_BYTE  = 2'd1;
  localparam logic [1:0] RS_EMPTY = 2'd2;
  localparam logic [1:0] RS_EOF   = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_char;
    logic       first_of_read;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic       dump_request;
    logic       line_committed;
    logic [1:0] read_status;
    logic [7:0] read_byte;
    logic       line_end;
  } out_item_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_DUMP,
    K_KILL,
    K_ERASE,
    K_STORE,
    K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_link_t;

endpackage

// ===== rtl/cle_front.sv =====
`timescale 1ns / 1ps
module cle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cle_pkg::in_item_t in_item,
  output logic              busy,
  input  logic              pop,
  output cle_pkg::q_link_t  q_out
);
  import cle_pkg::*;

  cmd_t               cls;
  cmd_t               fifo_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push, take;

  // Classify the received byte; CR is stored as LF.
  always_comb begin
    cls.ch    = in_item.rx_char;
    cls.first = in_item.first_of_read;
    if (in_item.op == OP_READ) begin
      cls.kind = K_READ;
    end else if (in_item.rx_char == CH_DUMP) begin
      cls.kind = K_DUMP;
    end else if (in_item.rx_char == CH_KILL) begin
      cls.kind = K_KILL;
    end else if (in_item.rx_char == CH_BS || in_item.rx_char == CH_DEL) begin
      cls.kind = K_ERASE;
    end else if (in_item.rx_char == CH_NUL) begin
      cls.kind = K_NOP;
    end else begin
      cls.kind = K_STORE;
      if (in_item.rx_char == CH_CR) begin
        cls.ch = CH_LF;
      end
    end
  end

  assign busy        = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push        = start && !busy;
  assign take        = pop && (cnt_r != '0);
  assign q_out.valid = (cnt_r != '0);
  assign q_out.cmd   = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + Q_PTR_W'(1);
      end
      if (take) begin
        rp_r <= (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + Q_PTR_W'(1);
      end
      if (push && !take) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (take && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/cle_back.sv =====
`timescale 1ns / 1ps
module cle_back #(
  parameter int BUF_DEPTH = cle_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cle_pkg::q_link_t   q_in,
  output logic               pop,
  output logic               out_valid,
  output cle_pkg::out_item_t out_item
);
  import cle_pkg::*;

  localparam int WRAP   = 2 * BUF_DEPTH;
  localparam int IDX_W  = $clog2(WRAP);
  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RDAT, S_KDAT} state_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(WRAP - 1)) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_W'(WRAP - 1) : a - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_diff(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + (IDX_W + 1)'(WRAP) - {1'b0, b};
    end
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] t;
    t = (a < IDX_W'(BUF_DEPTH)) ? a : a - IDX_W'(BUF_DEPTH);
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [CNT_W-1:0] c);
    logic [CNT_W+7:0] w;
    w = (CNT_W + 8)'(c);
    return (w > (CNT_W + 8)'(255)) ? 8'hFF : w[7:0];
  endfunction

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  cm_idx_r, cm_idx_nxt;
  logic [IDX_W-1:0]  ed_idx_r, ed_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic              emit;
  out_item_t         res;
  logic              we;
  logic [SLOT_W-1:0] raddr;
  logic [7:0]        rdata_r;
  logic [7:0]        line_store [BUF_DEPTH];
  logic [IDX_W-1:0]  ed_inc;

  assign ed_inc = idx_inc(ed_idx_r);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    rd_idx_nxt = rd_idx_r;
    cm_idx_nxt = cm_idx_r;
    ed_idx_nxt = ed_idx_r;
    cnt_nxt    = cnt_r;
    pop        = 1'b0;
    emit       = 1'b0;
    we         = 1'b0;
    raddr      = slot_of(rd_idx_r);
    res        = '0;
    res.read_status = RS_NONE;
    case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          pop       = 1'b1;
          cmd_nxt   = q_in.cmd;
          cnt_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        emit      = 1'b1;
        case (cmd_r.kind)
          K_DUMP: begin
            res.dump_request = 1'b1;
          end
          K_ERASE: begin
            if (ed_idx_r != cm_idx_r) begin
              ed_idx_nxt      = idx_dec(ed_idx_r);
              res.erase_count = 8'd1;
            end
          end
          K_STORE: begin
            if (idx_diff(ed_idx_r, rd_idx_r) < IDX_W'(BUF_DEPTH)) begin
              we             = 1'b1;
              res.echo_valid = 1'b1;
              res.echo_byte  = cmd_r.ch;
              ed_idx_nxt     = ed_inc;
              // commit on newline, end of file, or when this byte fills the ring
              if (cmd_r.ch == CH_LF || cmd_r.ch == CH_EOT ||
                  idx_diff(ed_idx_r, rd_idx_r) == IDX_W'(BUF_DEPTH - 1)) begin
                cm_idx_nxt         = ed_inc;
                res.line_committed = 1'b1;
              end
            end
          end
          K_KILL: begin
            if (ed_idx_r == cm_idx_r) begin
              res.erase_count = sat8(cnt_r);
            end else begin
              emit      = 1'b0;
              raddr     = slot_of(idx_dec(ed_idx_r));
              state_nxt = S_KDAT;
            end
          end
          K_READ: begin
            if (rd_idx_r == cm_idx_r) begin
              res.read_status = RS_EMPTY;
            end else begin
              emit      = 1'b0;
              state_nxt = S_RDAT;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDAT: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
        if (rdata_r == CH_EOT) begin
          // leave the end-of-file mark for the next call unless nothing was given yet
          res.read_status = RS_EOF;
          if (cmd_r.first) begin
            rd_idx_nxt = idx_inc(rd_idx_r);
          end
        end else begin
          rd_idx_nxt      = idx_inc(rd_idx_r);
          res.read_status = RS_BYTE;
          res.read_byte   = rdata_r;
          res.line_end    = (rdata_r == CH_LF);
        end
      end
      S_KDAT: begin
        if (rdata_r == CH_LF) begin
          emit            = 1'b1;
          res.erase_count = sat8(cnt_r);
          state_nxt       = S_IDLE;
        end else begin
          ed_idx_nxt = idx_dec(ed_idx_r);
          cnt_nxt    = cnt_r + CNT_W'(1);
          state_nxt  = S_EXEC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      line_store[slot_of(ed_idx_r)] <= cmd_r.ch;
    end
    rdata_r <= line_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      cm_idx_r    <= '0;
      ed_idx_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cm_idx_r    <= cm_idx_nxt;
      ed_idx_r    <= ed_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
    end
    cmd_r      <= cmd_nxt;
    out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/console_line_editor.sv =====
`timescale 1ns / 1ps
// Console line editor: cooked-mode input buffer for a serial console.
// Input: raise start with in_item; the item is taken at the edge where
//   start is high and busy is low. op 0 carries a received byte, op 1 asks
//   for one committed byte (first_of_read set on the first byte of a call).
// Output: one result item per input item, shown on out_item for exactly one
//   cycle while out_valid is high. The receiver cannot stall the block.
// Path: each item waits in the queue until S_IDLE pops it and S_EXEC works
//   it; reads answer from S_RDAT after the line store's registered read, and
//   a kill loops through S_EXEC and S_KDAT once per byte it walks back over.
// Throughput: set by the back end's state machine, which works one item at
//   a time, and the line store's single registered read port. A two-entry
//   queue between the classifier and the back end lets start be taken while
//   earlier items are still being worked.
// Reset (rst_n low, synchronous): indices and queue clear, busy falls, no
//   result is shown. The line store itself is not cleared; no entry is read
//   before it has been written.
module console_line_editor #(
  parameter int BUF_DEPTH = cle_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cle_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output cle_pkg::out_item_t out_item
);
  import cle_pkg::*;

  // front to back link: head of the command queue and its pop
  q_link_t q_link;
  logic    q_pop;

  // classify bytes and queue commands
  cle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .pop     (q_pop),
    .q_out   (q_link)
  );

  // edit the ring, serve reads and register each result
  cle_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (q_link),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/cle_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input cle_pkg::out_item_t out_item
);
  import cle_pkg::*;

  // reset empties the queue and drops any pending result
  `CLE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !busy && !out_valid)

  // a read result carries nothing from the editing side
  `CLE_ASSERT(a_read_alone, out_valid && out_item.read_status != RS_NONE |-> !out_item.echo_valid && out_item.erase_count == 8'd0 && !out_item.dump_request && !out_item.line_committed)

  // byte fields only on a delivered byte
  `CLE_ASSERT(a_byte_fields, out_valid && out_item.read_status != RS_BYTE |-> out_item.read_byte == 8'd0 && !out_item.line_end)

  // echoed bytes are never zero and never a raw CR
  `CLE_ASSERT(a_echo_mapped, out_valid && out_item.echo_valid |-> out_item.echo_byte != CH_NUL && out_item.echo_byte != CH_CR)

  // a line is committed only by storing a byte
  `CLE_ASSERT(a_commit_echo, out_valid && out_item.line_committed |-> out_item.echo_valid)

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

// ===== verif/line_edit_checker.sv =====
`timescale 1ns / 1ps
module line_edit_checker
  import cle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        errors,
  output int        pending
);

  localparam int DEPTH = DEFAULT_BUF_DEPTH;
  localparam int IX_W  = $clog2(2 * DEPTH);
  localparam int SL_W  = $clog2(DEPTH);

  logic [7:0]      ring [DEPTH];
  logic [IX_W-1:0] read_ix = '0;
  logic [IX_W-1:0] commit_ix = '0;
  logic [IX_W-1:0] edit_ix = '0;
  out_item_t       awaited_out [$];
  int              mismatch_cnt = 0;

  initial begin
    errors = 0;
    pending = 0;
    foreach (ring[i]) ring[i] = '0;
  end

  // Ring slot that an index points at.
  function automatic logic [SL_W-1:0] slot(logic [IX_W-1:0] ix);
    return SL_W'(ix % DEPTH);
  endfunction

  // Apply one item to the shadow ring and indices; return the response.
  function automatic out_item_t console_response(in_item_t it);
    out_item_t       r;
    logic [7:0]      ch;
    logic [7:0]      got;
    logic [IX_W-1:0] fill;
    int unsigned     wiped;
    r = '0;
    wiped = 0;
    ch = it.rx_char;
    if (it.op == OP_RX) begin
      fill = edit_ix - read_ix;
      if (ch == CH_DUMP) begin
        r.dump_request = 1'b1;
      end else if (ch == CH_KILL) begin
        while (edit_ix != commit_ix &&
               ring[slot(edit_ix - IX_W'(1))] != CH_LF) begin
          edit_ix = edit_ix - IX_W'(1);
          wiped++;
        end
      end else if (ch == CH_BS || ch == CH_DEL) begin
        if (edit_ix != commit_ix) begin
          edit_ix = edit_ix - IX_W'(1);
          wiped = 1;
        end
      end else if (ch != CH_NUL && int'(fill) < DEPTH) begin
        if (ch == CH_CR) ch = CH_LF;
        r.echo_valid = 1'b1;
        r.echo_byte = ch;
        ring[slot(edit_ix)] = ch;
        edit_ix = edit_ix + IX_W'(1);
        fill = edit_ix - read_ix;
        if (ch == CH_LF || ch == CH_EOT || int'(fill) == DEPTH) begin
          commit_ix = edit_ix;
          r.line_committed = 1'b1;
        end
      end
      r.erase_count = (wiped > 255) ? 8'd255 : 8'(wiped);
    end else if (read_ix == commit_ix) begin
      r.read_status = RS_EMPTY;
    end else begin
      got = ring[slot(read_ix)];
      if (got == CH_EOT) begin
        if (it.first_of_read) read_ix = read_ix + IX_W'(1);
        r.read_status = RS_EOF;
      end else begin
        read_ix = read_ix + IX_W'(1);
        r.read_status = RS_BYTE;
        r.read_byte = got;
        r.line_end = (got == CH_LF);
      end
    end
    return r;
  endfunction

  function automatic string describe(out_item_t o);
    return $sformatf("echo %0b/%02h erase %0d dump %0b commit %0b read %0d/%02h end %0b",
                     o.echo_valid, o.echo_byte, o.erase_count, o.dump_request,
                     o.line_committed, o.read_status, o.read_byte, o.line_end);
  endfunction

  task automatic flag_fault(string msg);
    if (mismatch_cnt < 10) $display("line_edit_checker: %s", msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      read_ix = '0;
      commit_ix = '0;
      edit_ix = '0;
      awaited_out.delete();
    end else begin
      if (out_valid) begin
        if (awaited_out.size() == 0) begin
          flag_fault($sformatf("unexpected result: %s", describe(out_item)));
        end else begin
          want = awaited_out.pop_front();
          if (out_item.echo_valid !== want.echo_valid ||
              out_item.echo_byte !== want.echo_byte ||
              out_item.erase_count !== want.erase_count ||
              out_item.dump_request !== want.dump_request ||
              out_item.line_committed !== want.line_committed ||
              out_item.read_status !== want.read_status ||
              out_item.read_byte !== want.read_byte ||
              out_item.line_end !== want.line_end) begin
            flag_fault($sformatf("mismatch at %0t\n  expected %s\n  actual   %s",
                                 $realtime, describe(want), describe(out_item)));
          end
        end
      end
      if (start && !busy) awaited_out.push_back(console_response(in_item));
    end
    errors <= mismatch_cnt;
    pending <= awaited_out.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import cle_pkg::*;

  // Roughly how many random items to send after the directed opening.
  localparam int ITEMS = 950;
  // Generous cycle ceiling: even a kill walking back over a full ring
  // costs little next to it, and such kills are rare.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Settle time after the last result: longer than the worst kill.
  localparam int DRAIN_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        errors;
  int        pending;

  int sent = 0;
  int cycles = 0;
  int idle_pct = 0;

  console_line_editor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // The checker watches both channels on its own and keeps the score.
  line_edit_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake must not hang the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. Idle gaps are
  // inserted before the item, so start drops for a whole number of cycles
  // and is never lowered and raised in the same step.
  task automatic push_item(logic op, logic [7:0] ch, logic first);
    in_item_t it;
    it.op = op;
    it.rx_char = ch;
    it.first_of_read = first;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    // busy as seen just after the edge is the value the edge itself saw
    do @(posedge clk); while (busy);
    // a NUL changes nothing in the ring, so leave it out of the tally
    if (!(op == OP_RX && ch == CH_NUL)) sent++;
  endtask

  // Received byte; first_of_read is unused here, so let it wander.
  task automatic key(logic [7:0] ch);
    push_item(OP_RX, ch, 1'($urandom_range(0, 1)));
  endtask

  // Read request; rx_char is unused here, so fill it with noise.
  task automatic fetch(logic first);
    push_item(OP_READ, 8'($urandom_range(0, 255)), first);
  endtask

  // One edited line: printable or high-bit bytes with the odd erase, kill or
  // dump, usually closed by LF, CR or Ctrl-D, sometimes left open.
  task automatic type_line();
    int n;
    int pick;
    n = $urandom_range(0, 10);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) key(8'($urandom_range(8'h20, 8'h7E)));
      else if (pick < 16) key(8'($urandom_range(8'h80, 8'hFF)));
      else if (pick == 16) key(CH_BS);
      else if (pick == 17) key(CH_DEL);
      else if (pick == 18) key(CH_KILL);
      else key(CH_DUMP);
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) key(CH_LF);
    else if (pick < 7) key(CH_CR);
    else if (pick < 9) key(CH_EOT);
  endtask

  // One read call: first byte flagged, then a few follow-on reads.
  task automatic read_call();
    fetch(1'b1);
    repeat ($urandom_range(0, 12)) fetch(1'b0);
  endtask

  // Fill the ring to the brim with no terminator so the full-buffer commit
  // fires and excess bytes are refused, then drain it all back out.
  task automatic fill_and_drain();
    repeat (DEFAULT_BUF_DEPTH + 3) key(8'($urandom_range(8'h20, 8'h7E)));
    key(CH_BS);
    key(CH_KILL);
    repeat (DEFAULT_BUF_DEPTH + 6) fetch(1'($urandom_range(0, 1)));
  endtask

  initial begin
    int pick;
    int phase;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty read, NUL, dump, erases on an empty line,
    // erase back over typed text, CR mapped to LF, kill of an open line,
    // Ctrl-D commit, a Ctrl-D left in place mid-call then consumed, and
    // the top byte value.
    fetch(1'b1);
    key(CH_NUL);
    key(CH_DUMP);
    key(CH_BS);
    key(CH_DEL);
    key(CH_KILL);
    key("a");
    key("b");
    key(CH_BS);
    key(CH_DEL);
    key("c");
    key("d");
    key(CH_CR);
    key("e");
    key(CH_KILL);
    key("f");
    key(CH_EOT);
    fetch(1'b1);
    fetch(1'b0);
    fetch(1'b0);
    fetch(1'b1);
    fetch(1'b0);
    fetch(1'b1);
    fetch(1'b1);
    key(8'hFF);

    // Random part, in four idling phases: none, sender idle about half the
    // time, none again (the receiver cannot stall), and sender idle 20%.
    sent = 0;
    while (sent < ITEMS) begin
      phase = (sent * 4) / ITEMS;
      case (phase)
        1: idle_pct = 51;
        3: idle_pct = 20;
        default: idle_pct = 0;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        type_line();
        read_call();
      end else if (pick < 67) begin
        fill_and_drain();
      end else begin
        // noise: anything at all, either operation
        repeat ($urandom_range(1, 6)) begin
          push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
    start <= 1'b0;

    // Let the checker see the last acceptance, wait for every result, then
    // hold a while longer to catch any stray output.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
